// ===== rtl/pcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpg_pkg
// Shared constants, types and shape tables of the parametric curve point
// generator, with the quarter-wave sine contents built at elaboration.
// ----------------------------------------------------------------------------
package pcpg_pkg;

   // Sine table: phases per full turn (power of two) and fraction bits
   localparam int TABLE_ENTRIES = 256;
   localparam int FRAC_BITS     = 14;

   localparam int PHASE_W   = $clog2(TABLE_ENTRIES);
   localparam int QUARTER   = TABLE_ENTRIES / 4;
   localparam int ROM_DEPTH = QUARTER + 1;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int FILL_W    = $clog2(ROM_DEPTH + 1);

   // Field widths
   localparam int STEP_W   = 8;
   localparam int SHAPE_W  = 3;
   localparam int CENTER_W = 11;
   localparam int PIX_W    = 13;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = CENTER_W;
   localparam int REQ_DW   = 8;
   localparam int RSP_DW   = 56;

   // Datapath widths
   localparam int MAG_W     = FRAC_BITS + 1;        // |sin| up to 1.0
   localparam int SIN_W     = FRAC_BITS + 2;        // signed sine
   localparam int T_W       = FRAC_BITS + 6;        // t below 12*pi
   localparam int BASE_W    = FRAC_BITS + 7;        // unscaled point
   localparam int SCALE_W   = 7;
   localparam int SCALED_W  = BASE_W + SCALE_W + 1;
   localparam int VAL_W     = SCALED_W + 1;
   localparam int TURN_W    = 2;
   localparam int LOG_W     = 4;
   localparam int KP_W      = STEP_W + TURN_W;      // k * turns
   localparam int KT_W      = KP_W + 1;             // k * 2 * turns
   localparam int PI_W      = 32;
   localparam int TPROD_W   = KT_W + PI_W;
   localparam int T_SHIFT   = 30 - FRAC_BITS;
   localparam int SHAMT_W   = 6;

   localparam logic [PI_W-1:0] PI_Q30      = 32'd3373259426;
   localparam logic [63:0]     HALF_PI_Q30 = 64'd1686629713;

   // Shape codes
   localparam logic [SHAPE_W-1:0] SHAPE_ASTROID = 3'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_CYCLOID = 3'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_HUYGENS = 3'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_HYPO    = 3'd3;
   localparam logic [SHAPE_W-1:0] SHAPE_LINE    = 3'd4;
   localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE  = 3'd5;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_SHAPE    = 2'd0;
   localparam logic [CSR_AW-1:0] REG_CENTER_X = 2'd1;
   localparam logic [CSR_AW-1:0] REG_CENTER_Y = 2'd2;

   // Sine lookup request from the sequencer
   typedef struct packed {
      logic               rd_en;
      logic [PHASE_W-1:0] phase;
   } sine_req_type;

   typedef logic [MAG_W-1:0] sine_rom_type [ROM_DEPTH];

   // Taylor series divisors (2n)(2n+1)
   localparam logic [63:0] TAYLOR_DIV [10] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
      64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

   // Quarter-wave sine in Q30 by truncated Taylor steps, rounded to FRAC_BITS
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      r;
      int          n;
      x    = (64'(q) * HALF_PI_Q30) / QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 0; n < 10; n++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[n];
         if ((n & 1) == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (r > (longint'(1) <<< FRAC_BITS)) begin
         r = longint'(1) <<< FRAC_BITS;
      end
      return r[MAG_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int           q;
      for (q = 0; q < ROM_DEPTH; q++) begin
         rom[q] = quarter_sine(q);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Turns of the table per curve interval
   function automatic logic [TURN_W-1:0] shape_turns(input logic [SHAPE_W-1:0] shape);
      unique case (shape)
         SHAPE_ASTROID: return 2'd1;
         SHAPE_CYCLOID: return 2'd3;
         SHAPE_HUYGENS: return 2'd2;
         SHAPE_HYPO:    return 2'd1;
         SHAPE_LINE:    return 2'd1;
         SHAPE_CIRCLE:  return 2'd1;
         default:       return 2'd0;
      endcase
   endfunction

   // log2 of the step count
   function automatic logic [LOG_W-1:0] shape_steps_log(input logic [SHAPE_W-1:0] shape);
      unique case (shape)
         SHAPE_CYCLOID: return 4'd7;
         SHAPE_CIRCLE:  return 4'd7;
         default:       return 4'd8;
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] shape_scale(input logic [SHAPE_W-1:0] shape);
      unique case (shape)
         SHAPE_ASTROID: return 7'd80;
         SHAPE_CYCLOID: return 7'd6;
         SHAPE_HUYGENS: return 7'd16;
         SHAPE_HYPO:    return 7'd12;
         SHAPE_LINE:    return 7'd5;
         SHAPE_CIRCLE:  return 7'd50;
         default:       return 7'd0;
      endcase
   endfunction

   function automatic logic shape_valid(input logic [SHAPE_W-1:0] shape);
      return (shape == SHAPE_ASTROID) || (shape == SHAPE_CYCLOID) ||
             (shape == SHAPE_HUYGENS) || (shape == SHAPE_HYPO) ||
             (shape == SHAPE_LINE) || (shape == SHAPE_CIRCLE);
   endfunction

endpackage

// ===== rtl/pcpg_ram.sv =====
// ----------------------------------------------------------------------------
// pcpg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pcpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcpg_sine.sv =====
// ----------------------------------------------------------------------------
// pcpg_sine
// Quarter-wave sine memory: filled once after reset, then folds a full-turn
// phase onto the quarter and returns the signed sine in the following cycle.
// ----------------------------------------------------------------------------
module pcpg_sine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcpg_pkg::sine_req_type                sin_req,
   output logic                                  fill_done,
   output logic signed [pcpg_pkg::SIN_W-1:0]     sin_value
);
   import pcpg_pkg::*;

   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic               filling;
   logic [1:0]         quad;
   logic [ROM_AW-1:0]  rem;
   logic [ROM_AW-1:0]  rd_addr;
   logic               neg_ff;
   logic               neg_in;
   logic [MAG_W-1:0]   rd_data;
   logic signed [SIN_W-1:0] mag_s;

   // Fill sweep, one entry per cycle
   assign filling = (fill_ff != FILL_W'(ROM_DEPTH));
   assign fill_in = filling ? fill_ff + 1'b1 : fill_ff;
   assign fill_done = !filling;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Fold phase: odd quadrants mirror, upper half negates
   assign quad    = sin_req.phase[PHASE_W-1 -: 2];
   assign rem     = ROM_AW'(sin_req.phase[PHASE_W-3:0]);
   assign rd_addr = quad[0] ? ROM_AW'(QUARTER) - rem : rem;
   assign neg_in  = sin_req.rd_en ? quad[1] : neg_ff;

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   pcpg_ram #(
      .WIDTH (MAG_W),
      .DEPTH (ROM_DEPTH)
   ) u_rom (
      .clock   (clock),
      .wr_en   (filling),
      .wr_addr (fill_ff[ROM_AW-1:0]),
      .wr_data (SINE_ROM[fill_ff[ROM_AW-1:0]]),
      .rd_en   (sin_req.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mag_s     = $signed({1'b0, rd_data});
   assign sin_value = neg_ff ? -mag_s : mag_s;

endmodule

// ===== rtl/parametric_curve_point_generator.sv =====
// ----------------------------------------------------------------------------
// parametric_curve_point_generator
// Works out one pixel of the selected curve per step index and emits it
// together with the previous in-range pixel as one line segment.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | tdata: step_index                         | tvalid/tready
//   rsp     | out | tdata: pixel x/y, prev x/y; tuser; tlast  | tvalid/tready
//   csr     | in  | shape_select, center_x, center_y          | csr_wr_en
//
// An item runs from accept through four reads of the sine memory, then the
// base, scale and pixel steps; the astroid adds four passes through the
// shared multiplier. The next item is taken only after the pixel step.
// After reset the sine memory is filled, all ROM_DEPTH (65) entries, with
// req_tready low; csr writes are taken during that time.
// A new item is taken while a result waits in the output register; a
// stalled rsp side holds the block only in its final pixel step.
// ----------------------------------------------------------------------------
module parametric_curve_point_generator (
   input  logic                              clock,
   input  logic                              reset,
   // csr
   input  logic                              csr_wr_en,
   input  logic [pcpg_pkg::CSR_AW-1:0]       csr_addr,
   input  logic [pcpg_pkg::CSR_DW-1:0]       csr_wdata,
   // req: tdata = step_index[7:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pcpg_pkg::REQ_DW-1:0]       req_tdata,
   // rsp: tdata = pixel_x, pixel_y, prev_pixel_x, prev_pixel_y, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcpg_pkg::RSP_DW-1:0]       rsp_tdata,
   output logic                              rsp_tuser,   // in_range
   output logic                              rsp_tlast    // last_point
);
   import pcpg_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_C     = 13'b0000000000010,
      S_S     = 13'b0000000000100,
      S_CM    = 13'b0000000001000,
      S_SM    = 13'b0000000010000,
      S_LAST  = 13'b0000000100000,
      S_M0    = 13'b0000001000000,
      S_M1    = 13'b0000010000000,
      S_M2    = 13'b0000100000000,
      S_M3    = 13'b0001000000000,
      S_BASE  = 13'b0010000000000,
      S_SCALE = 13'b0100000000000,
      S_PIX   = 13'b1000000000000
   } state_type;

   // Truncate a Q value toward zero to a 13-bit pixel
   function automatic logic [PIX_W-1:0] to_pixel(input logic signed [VAL_W-1:0] v);
      logic [VAL_W-1:0] mag;
      logic [VAL_W-1:0] q;
      mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
      q   = mag >> FRAC_BITS;
      return v[VAL_W-1] ? -q[PIX_W-1:0] : q[PIX_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [SHAPE_W-1:0]  shape_ff, shape_in;
   logic [CENTER_W-1:0] center_x_ff, center_x_in;
   logic [CENTER_W-1:0] center_y_ff, center_y_in;

   logic [STEP_W-1:0]   k_ff, k_in;
   logic [T_W-1:0]      t_ff, t_in;
   logic signed [SIN_W-1:0] c_ff, c_in, s_ff, s_in, cm_ff, cm_in, sm_ff, sm_in;
   logic [MAG_W-1:0]    sq_ff, sq_in;
   logic signed [SIN_W-1:0] cube_x_ff, cube_x_in, cube_y_ff, cube_y_in;
   logic signed [BASE_W-1:0] base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic signed [SCALED_W-1:0] scaled_x_ff, scaled_x_in, scaled_y_ff, scaled_y_in;
   logic [PIX_W-1:0]    held_x_ff, held_x_in, held_y_ff, held_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    px_ff, px_in, py_ff, py_in, prx_ff, prx_in, pry_ff, pry_in;
   logic                inr_ff, inr_in, last_ff, last_in;

   logic                req_accept;
   logic                out_free;
   logic                fill_done;
   sine_req_type        sin_req;
   logic signed [SIN_W-1:0] sin_value;

   logic [TURN_W-1:0]   turns;
   logic [LOG_W-1:0]    steps_log;
   logic [SCALE_W-1:0]  scale;
   logic                valid_shape;
   logic [KP_W-1:0]     kt;
   logic [KP_W+PHASE_W-1:0] phase_full;
   logic [PHASE_W-1:0]  p, mp;
   logic [KT_W-1:0]     kt2;
   logic [TPROD_W-1:0]  tprod;
   logic [SHAMT_W-1:0]  t_shamt;

   logic [MAG_W-1:0]    abs_c, abs_s;
   logic [MAG_W-1:0]    mul_a, mul_b;
   logic [2*MAG_W-1:0]  mul_p;
   logic [MAG_W-1:0]    mul_q;
   logic signed [SIN_W-1:0] mul_q_s;

   logic signed [BASE_W-1:0] c_w, s_w, cm_w, sm_w, t_w, one_w;
   logic signed [SCALE_W:0]  scale_s;
   logic signed [VAL_W-1:0]  cen_x_w, cen_y_w, v_x, v_y;
   logic [PIX_W-1:0]    pix_x, pix_y;
   logic                inr_w, last_w;
   logic [STEP_W:0]     k_ext;

   // Shape lookups
   assign turns       = shape_turns(shape_ff);
   assign steps_log   = shape_steps_log(shape_ff);
   assign scale       = shape_scale(shape_ff);
   assign valid_shape = shape_valid(shape_ff);

   // Table phase p = k * turns * TABLE_ENTRIES / steps, wrapped
   assign kt         = KP_W'(k_ff) * KP_W'(turns);
   assign phase_full = {kt, {PHASE_W{1'b0}}} >> steps_log;
   assign p          = phase_full[PHASE_W-1:0];
   assign mp         = (shape_ff == SHAPE_HUYGENS) ? p + (p << 1) : (p << 1);

   // t = k * 2 * turns * pi / steps, in Q FRAC_BITS
   assign kt2     = {kt, 1'b0};
   assign tprod   = TPROD_W'(kt2) * TPROD_W'(PI_Q30);
   assign t_shamt = SHAMT_W'(steps_log) + SHAMT_W'(T_SHIFT);
   assign t_in    = (state_ff == S_C) ? T_W'(tprod >> t_shamt) : t_ff;

   // Handshake
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && fill_done;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes
   always_comb begin
      shape_in    = shape_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            REG_SHAPE:    shape_in    = csr_wdata[SHAPE_W-1:0];
            REG_CENTER_X: center_x_in = csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y: center_y_in = csr_wdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // Sine memory reads: cos p, sin p, cos mp, sin mp
   always_comb begin
      sin_req.rd_en = 1'b1;
      sin_req.phase = p;
      unique case (state_ff)
         S_C:     sin_req.phase = p + PHASE_W'(QUARTER);
         S_S:     sin_req.phase = p;
         S_CM:    sin_req.phase = mp + PHASE_W'(QUARTER);
         S_SM:    sin_req.phase = mp;
         default: sin_req.rd_en = 1'b0;
      endcase
   end

   pcpg_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .sin_req   (sin_req),
      .fill_done (fill_done),
      .sin_value (sin_value)
   );

   // Capture of read data in the state after each read
   assign c_in  = (state_ff == S_S)    ? sin_value : c_ff;
   assign s_in  = (state_ff == S_CM)   ? sin_value : s_ff;
   assign cm_in = (state_ff == S_SM)   ? sin_value : cm_ff;
   assign sm_in = (state_ff == S_LAST) ? sin_value : sm_ff;

   // Shared multiplier for the astroid cubes
   assign abs_c = MAG_W'(c_ff[SIN_W-1] ? -c_ff : c_ff);
   assign abs_s = MAG_W'(s_ff[SIN_W-1] ? -s_ff : s_ff);

   always_comb begin
      mul_a = abs_c;
      mul_b = abs_c;
      unique case (state_ff)
         S_M1:    mul_a = sq_ff;
         S_M2: begin
            mul_a = abs_s;
            mul_b = abs_s;
         end
         S_M3: begin
            mul_a = sq_ff;
            mul_b = abs_s;
         end
         default: ;
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_q   = mul_p[FRAC_BITS +: MAG_W];
   assign mul_q_s = $signed({1'b0, mul_q});

   assign sq_in     = ((state_ff == S_M0) || (state_ff == S_M2)) ? mul_q : sq_ff;
   assign cube_x_in = (state_ff == S_M1) ? (c_ff[SIN_W-1] ? -mul_q_s : mul_q_s) : cube_x_ff;
   assign cube_y_in = (state_ff == S_M3) ? (s_ff[SIN_W-1] ? -mul_q_s : mul_q_s) : cube_y_ff;

   // Unscaled point per shape
   assign c_w   = BASE_W'(c_ff);
   assign s_w   = BASE_W'(s_ff);
   assign cm_w  = BASE_W'(cm_ff);
   assign sm_w  = BASE_W'(sm_ff);
   assign t_w   = $signed(BASE_W'(t_ff));
   assign one_w = $signed(BASE_W'(1) << FRAC_BITS);

   always_comb begin
      base_x_in = base_x_ff;
      base_y_in = base_y_ff;
      if (state_ff == S_BASE) begin
         unique case (shape_ff)
            SHAPE_ASTROID: begin
               base_x_in = BASE_W'(cube_x_ff);
               base_y_in = BASE_W'(cube_y_ff);
            end
            SHAPE_CYCLOID: begin
               base_x_in = one_w - c_w;
               base_y_in = t_w - s_w;
            end
            SHAPE_HUYGENS: begin
               base_x_in = (c_w <<< 1) + c_w - cm_w;
               base_y_in = (s_w <<< 1) + s_w - sm_w;
            end
            SHAPE_HYPO: begin
               base_x_in = (c_w <<< 1) + cm_w;
               base_y_in = (s_w <<< 1) - sm_w;
            end
            SHAPE_LINE: begin
               base_x_in = one_w - t_w;
               base_y_in = one_w - t_w;
            end
            SHAPE_CIRCLE: begin
               base_x_in = c_w;
               base_y_in = s_w;
            end
            default: begin
               base_x_in = '0;
               base_y_in = '0;
            end
         endcase
      end
   end

   // Shape scale
   assign scale_s     = $signed({1'b0, scale});
   assign scaled_x_in = (state_ff == S_SCALE) ?
                        SCALED_W'(base_x_ff) * SCALED_W'(scale_s) : scaled_x_ff;
   assign scaled_y_in = (state_ff == S_SCALE) ?
                        SCALED_W'(base_y_ff) * SCALED_W'(scale_s) : scaled_y_ff;

   // Center offset and truncation to pixels
   assign cen_x_w = $signed(VAL_W'({center_x_ff, {FRAC_BITS{1'b0}}}));
   assign cen_y_w = $signed(VAL_W'({center_y_ff, {FRAC_BITS{1'b0}}}));
   assign v_x     = VAL_W'(scaled_x_ff) + cen_x_w;
   assign v_y     = VAL_W'(scaled_y_ff) + cen_y_w;
   assign pix_x   = to_pixel(v_x);
   assign pix_y   = to_pixel(v_y);

   // Range flags
   assign k_ext  = (STEP_W+1)'(k_ff);
   assign inr_w  = valid_shape && ((k_ext >> steps_log) == '0);
   assign last_w = valid_shape && (k_ext == (((STEP_W+1)'(1) << steps_log) - 1'b1));

   // Output register and held segment start
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      px_in        = px_ff;
      py_in        = py_ff;
      prx_in       = prx_ff;
      pry_in       = pry_ff;
      inr_in       = inr_ff;
      last_in      = last_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      if ((state_ff == S_PIX) && out_free) begin
         rsp_valid_in = 1'b1;
         px_in        = pix_x;
         py_in        = pix_y;
         inr_in       = inr_w;
         last_in      = last_w;
         if (inr_w && (k_ff == '0)) begin
            prx_in = pix_x;
            pry_in = pix_y;
         end else begin
            prx_in = held_x_ff;
            pry_in = held_y_ff;
         end
         if (inr_w) begin
            held_x_in = pix_x;
            held_y_in = pix_y;
         end
      end
   end

   assign k_in = req_accept ? req_tdata[STEP_W-1:0] : k_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_accept) state_in = S_C;
         S_C:     state_in = S_S;
         S_S:     state_in = S_CM;
         S_CM:    state_in = S_SM;
         S_SM:    state_in = S_LAST;
         S_LAST:  state_in = (shape_ff == SHAPE_ASTROID) ? S_M0 : S_BASE;
         S_M0:    state_in = S_M1;
         S_M1:    state_in = S_M2;
         S_M2:    state_in = S_M3;
         S_M3:    state_in = S_BASE;
         S_BASE:  state_in = S_SCALE;
         S_SCALE: state_in = S_PIX;
         S_PIX:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shape_ff     <= SHAPE_ASTROID;
         center_x_ff  <= CENTER_W'(200);
         center_y_ff  <= CENTER_W'(200);
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shape_ff     <= shape_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      t_ff        <= t_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      cm_ff       <= cm_in;
      sm_ff       <= sm_in;
      sq_ff       <= sq_in;
      cube_x_ff   <= cube_x_in;
      cube_y_ff   <= cube_y_in;
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      scaled_x_ff <= scaled_x_in;
      scaled_y_ff <= scaled_y_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      prx_ff      <= prx_in;
      pry_ff      <= pry_in;
      inr_ff      <= inr_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DW - 4*PIX_W)'(0), pry_ff, prx_ff, py_ff, px_ff};
   assign rsp_tuser  = inr_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/pcpg_checker.sv =====
// ----------------------------------------------------------------------------
// pcpg_checker
// Port-level checks of the curve point generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcpg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pcpg_pkg::RSP_DW-1:0]       rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import pcpg_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // One item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while previous item in work");

   // Sine memory fill keeps the input closed right after reset
   a_fill_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("req ready during sine memory fill");

   // The last point of a curve is always in range
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last point flagged out of range");

endmodule

bind parametric_curve_point_generator pcpg_checker u_pcpg_checker (.*);
